// ----- hdl/unsigned_restoring_divider_defines.svh -----
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef UNSIGNED_RESTORING_DIVIDER_DEFINES_SVH
`define UNSIGNED_RESTORING_DIVIDER_DEFINES_SVH

`define URDIV_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("urdiv assertion failed");

`define URDIV_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("urdiv assertion failed");

`endif

// ----- hdl/urdiv_pkg.sv -----
package urdiv_pkg;

  localparam int unsigned DATA_WIDTH = 32;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] dividend_value;
    logic [DATA_WIDTH-1:0] divisor_value;
  } in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] quotient_value;
    logic [DATA_WIDTH-1:0] remainder_value;
    logic                  zero_divisor;
  } out_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] part;
    logic [DATA_WIDTH-1:0] quo;
    logic [DATA_WIDTH-1:0] den;
    logic                  zero;
  } stage_t;

endpackage

// ----- hdl/urdiv_if.sv -----
interface urdiv_in_if import urdiv_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface urdiv_out_if import urdiv_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/urdiv_step.sv -----
module urdiv_step import urdiv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  stage_t stage_i,
  output logic   valid_o,
  output stage_t stage_o
);

  logic                  valid_q;
  stage_t                stage_q;
  stage_t                stage_d;
  logic [DATA_WIDTH-1:0] shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  take;

  // shift in the next dividend bit, trial subtract, restore on borrow
  always_comb begin
    shifted = {stage_i.part[DATA_WIDTH-2:0], stage_i.quo[DATA_WIDTH-1]};
    diff    = {stage_i.part[DATA_WIDTH-1], shifted} - {1'b0, stage_i.den};
    take    = ~diff[DATA_WIDTH];
    stage_d      = stage_i;
    stage_d.part = take ? diff[DATA_WIDTH-1:0] : shifted;
    stage_d.quo  = {stage_i.quo[DATA_WIDTH-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ----- hdl/urdiv_skid.sv -----
`include "unsigned_restoring_divider_defines.svh"

module urdiv_skid import urdiv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic up_valid_i,
  input  out_t up_data_i,
  output logic up_ready_o,
  urdiv_out_if.source out_o
);

  logic out_valid_q;
  logic out_valid_d;
  out_t out_data_q;
  out_t out_data_d;
  logic skid_valid_q;
  logic skid_valid_d;
  out_t skid_data_q;
  out_t skid_data_d;
  logic push;

  assign up_ready_o = ~skid_valid_q;
  assign push       = up_valid_i & ~skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_data_d  = up_data_i;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_data_d  = up_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  `URDIV_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q)
  `URDIV_ASSERT_NEXT(a_skid_catches, push && out_valid_q && !out_o.ready, skid_valid_q)
  `URDIV_ASSERT_NEXT(a_skid_drains, skid_valid_q && out_o.ready, out_valid_q && !skid_valid_q)

endmodule

// ----- hdl/unsigned_restoring_divider.sv -----
// Pipelined 32-bit unsigned restoring divider. Each transfer on in_i carries a dividend and
// a divisor; each transfer on out_o returns the quotient, the remainder and a zero-divisor
// flag, in input order. One shift-subtract-restore step per register stage, with 32 step stages
// plus the output register, gives a sustained rate of one division per cycle while out_o takes
// results. A two-entry output buffer keeps accepting while a result waits; once it is full
// the whole pipeline holds and in_i.ready stays low until the cycle after out_o takes a
// result. A zero divisor returns quotient 0, the dividend as remainder, and zero_divisor set.
`include "unsigned_restoring_divider_defines.svh"

module unsigned_restoring_divider import urdiv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  urdiv_in_if.sink    in_i,
  urdiv_out_if.source out_o
);

  logic   pipe_valid [DATA_WIDTH+1];
  stage_t pipe_stage [DATA_WIDTH+1];
  logic   en;
  out_t   result;

  assign in_i.ready    = en;
  assign pipe_valid[0] = in_i.valid;
  assign pipe_stage[0] = {{DATA_WIDTH{1'b0}}, in_i.data.dividend_value,
                          in_i.data.divisor_value, (in_i.data.divisor_value == '0)};

  for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
    urdiv_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (pipe_valid[g]),
      .stage_i (pipe_stage[g]),
      .valid_o (pipe_valid[g+1]),
      .stage_o (pipe_stage[g+1])
    );
  end

  always_comb begin
    result.quotient_value  = pipe_stage[DATA_WIDTH].zero ? '0 : pipe_stage[DATA_WIDTH].quo;
    result.remainder_value = pipe_stage[DATA_WIDTH].part;
    result.zero_divisor    = pipe_stage[DATA_WIDTH].zero;
  end

  urdiv_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (pipe_valid[DATA_WIDTH]),
    .up_data_i  (result),
    .up_ready_o (en),
    .out_o      (out_o)
  );

  `URDIV_ASSERT_IMPL(a_zero_quotient,
                     pipe_valid[DATA_WIDTH] && result.zero_divisor,
                     result.quotient_value == '0)
  `URDIV_ASSERT_NEXT(a_hold_on_stall, !en, $stable(pipe_valid[DATA_WIDTH]))
  `URDIV_ASSERT_IMPL(a_flag_matches_den,
                     pipe_valid[DATA_WIDTH],
                     pipe_stage[DATA_WIDTH].zero == (pipe_stage[DATA_WIDTH].den == '0))

endmodule

// ----- bench/unsigned_restoring_divider_tb.sv -----
`timescale 1ns / 1ps

module unsigned_restoring_divider_tb import urdiv_pkg::*; ();

  localparam int NUM_DIRECTED  = 21;
  localparam int NUM_RANDOM    = 1750;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AT       = 400;
  localparam int PAUSE_AT      = 900;
  localparam int STEADY_FIRST  = 1100;
  localparam int STEADY_LAST   = 1300;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
    logic                  known;
    out_t                  typed;
  } division_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  urdiv_in_if  in_bus ();
  urdiv_out_if out_bus ();

  unsigned_restoring_divider u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  out_t pending_quotients[$];
  int   errors = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   zero_div_items = 0;
  int   high_div_items = 0;
  bit   long_hold_done = 1'b0;
  bit   drain_pause_done = 1'b0;

  division_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b1}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1}},
    '{32'h1234_5678, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h1234_5678, 1'b1}},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'hFFFF_FFFE, 1'b0}},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
    '{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0000_0001, 32'h7FFF_FFFF, 1'b0}},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0000_0000, 32'h7FFF_FFFF, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0002, 1'b1, '{32'h7FFF_FFFF, 32'h0000_0001, 1'b0}},
    '{32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h8000_0000, 32'h0000_0000, 1'b0}},
    '{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, '{32'h0000_0002, 32'h0000_0000, 1'b0}},
    '{32'h1234_5678, 32'h0000_9ABC, 1'b0, '0},
    '{32'hDEAD_BEEF, 32'h8000_0001, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
    '{32'hC000_0000, 32'hA000_0000, 1'b0, '0},
    '{32'h0000_0064, 32'h0000_0007, 1'b0, '0},
    '{32'h5555_5555, 32'h0000_0003, 1'b0, '0}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic out_t restoring_quotient(logic [DATA_WIDTH-1:0] num,
                                              logic [DATA_WIDTH-1:0] den);
    logic [DATA_WIDTH:0]   part;
    logic [DATA_WIDTH-1:0] quo;
    out_t                  res;
    if (den == '0) begin
      res.quotient_value  = '0;
      res.remainder_value = num;
      res.zero_divisor    = 1'b1;
    end else begin
      part = '0;
      quo  = num;
      for (int step = 0; step < DATA_WIDTH; step++) begin
        part = {part[DATA_WIDTH-1:0], quo[DATA_WIDTH-1]};
        quo  = quo << 1;
        if (part >= {1'b0, den}) begin
          part   = part - {1'b0, den};
          quo[0] = 1'b1;
        end
      end
      res.quotient_value  = quo;
      res.remainder_value = part[DATA_WIDTH-1:0];
      res.zero_divisor    = 1'b0;
    end
    return res;
  endfunction

  function automatic in_t random_operands();
    in_t op;
    int  pick;
    pick = $urandom_range(0, 99);
    op.dividend_value = $urandom();
    op.divisor_value  = $urandom();
    if (pick < 6) begin
      op.divisor_value = '0;
    end else if (pick < 26) begin
      op.divisor_value = $urandom_range(1, 255);
    end else if (pick < 46) begin
      op.divisor_value = op.divisor_value | 32'h8000_0000;
      if (pick < 36) op.dividend_value = op.dividend_value | 32'h8000_0000;
    end else if (pick < 60) begin
      op.divisor_value = op.dividend_value + $urandom_range(0, 8) - 4;
    end else if (pick < 70) begin
      op.dividend_value = op.dividend_value >> $urandom_range(8, 31);
    end else begin
      op.divisor_value = op.divisor_value >> $urandom_range(0, 31);
    end
    return op;
  endfunction

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(string name, logic [DATA_WIDTH-1:0] want,
                             logic [DATA_WIDTH-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic send_division(in_t op, logic known, out_t typed, int gap);
    out_t want;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= op;
    do @(posedge clk_i); while (!in_bus.ready);
    want = known ? typed : restoring_quotient(op.dividend_value, op.divisor_value);
    pending_quotients.push_back(want);
    items_sent++;
    if (op.divisor_value == '0) zero_div_items++;
    if (op.divisor_value[DATA_WIDTH-1]) high_div_items++;
  endtask

  // receiver: checks each transfer and throttles ready
  initial begin
    int   idle_left;
    bit   steady;
    out_t want;
    idle_left     = 0;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        if (pending_quotients.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_bus.data);
        end else begin
          want = pending_quotients.pop_front();
          check_field("quotient", want.quotient_value, out_bus.data.quotient_value);
          check_field("remainder", want.remainder_value, out_bus.data.remainder_value);
          check_field("zero_divisor", 32'(want.zero_divisor),
                      32'(out_bus.data.zero_divisor));
        end
        results_seen++;
      end
      steady = (results_seen >= STEADY_FIRST) && (results_seen <= STEADY_LAST);
      if (results_seen == HOLD_AT && !long_hold_done) begin
        long_hold_done = 1'b1;
        idle_left      = LONG_HOLD;
      end
      if (idle_left > 0) begin
        idle_left--;
        out_bus.ready <= 1'b0;
      end else if (steady) begin
        out_bus.ready <= 1'b1;
      end else begin
        idle_left     = pick_gap();
        out_bus.ready <= (idle_left == 0);
        if (idle_left > 0) idle_left--;
      end
    end
  end

  initial begin
    in_t op;
    int  gap;
    rst_ni       <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.data  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int row = 0; row < NUM_DIRECTED; row++) begin
      op.dividend_value = directed_rows[row].dividend;
      op.divisor_value  = directed_rows[row].divisor;
      send_division(op, directed_rows[row].known, directed_rows[row].typed, pick_gap());
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (items_sent == PAUSE_AT) begin
        in_bus.valid <= 1'b0;
        while (pending_quotients.size() != 0) @(posedge clk_i);
        drain_pause_done = 1'b1;
      end
      // back-to-back offers around the long output hold and the steady stretch
      if ((items_sent >= HOLD_AT && items_sent < HOLD_AT + 360) ||
          (items_sent >= STEADY_FIRST && items_sent <= STEADY_LAST + 30))
        gap = 0;
      else
        gap = pick_gap();
      send_division(random_operands(), 1'b0, '0, gap);
    end
    in_bus.valid <= 1'b0;

    while (pending_quotients.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d divisions (%0d by zero, %0d by divisors with the top bit set)",
             items_sent, zero_div_items, high_div_items);
    $display("long output hold %0s, drain pause %0s, %0d results checked",
             long_hold_done ? "done" : "missed", drain_pause_done ? "done" : "missed",
             results_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_quotients.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
